[hdl/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, codes and constants shared by the odometry core modules.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_STEPS   = 30;
    localparam int DIV_W          = 64;
    localparam int MUL_W          = 35;
    localparam int CS_W           = 33;   // CORDIC x/y width
    localparam int CZ_W           = 34;   // CORDIC residual angle width

    localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [31:0] INV_PI_Q32     = 32'd1367130551;

    localparam logic [15:0] WHEEL_BASE_RST = 16'd3840;
    localparam logic [15:0] DIST_TICK_RST  = 16'd19903;

    // configuration register indexes
    localparam logic REG_WHEEL_BASE = 1'b0;
    localparam logic REG_DIST_TICK  = 1'b1;

    // datapath operations
    localparam logic [4:0] OP_NONE = 5'd0;
    localparam logic [4:0] OP_LOAD = 5'd1;
    localparam logic [4:0] OP_ML   = 5'd2;
    localparam logic [4:0] OP_MR   = 5'd3;
    localparam logic [4:0] OP_SD   = 5'd4;
    localparam logic [4:0] OP_MQ   = 5'd5;
    localparam logic [4:0] OP_DQ   = 5'd6;
    localparam logic [4:0] OP_Q    = 5'd7;
    localparam logic [4:0] OP_CHK  = 5'd8;
    localparam logic [4:0] OP_CH   = 5'd9;
    localparam logic [4:0] OP_MS   = 5'd10;
    localparam logic [4:0] OP_DF   = 5'd11;
    localparam logic [4:0] OP_F    = 5'd12;
    localparam logic [4:0] OP_CM   = 5'd13;
    localparam logic [4:0] OP_MC   = 5'd14;
    localparam logic [4:0] OP_TC   = 5'd15;
    localparam logic [4:0] OP_MX   = 5'd16;
    localparam logic [4:0] OP_DX   = 5'd17;
    localparam logic [4:0] OP_TS   = 5'd18;
    localparam logic [4:0] OP_MY   = 5'd19;
    localparam logic [4:0] OP_DY   = 5'd20;
    localparam logic [4:0] OP_DONE = 5'd21;

    typedef struct packed {
        logic [4:0] op;
        logic       in_ready;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic cor_done;
        logic q_zero;
        logic out_free;
    } dp_status_t;

    // arctangent of 2^-i in 2^32-per-turn units
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/ddo_div.sv]
// ----------------------------------------------------------------------------
// ddo_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div import ddo_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] dsr_reg;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   rem_t;
    logic [DIV_W:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_t    = {rem_reg, dvd_reg[DIV_W-1]};
        rem_sub  = rem_t - {1'b0, dsr_reg};
        ge       = !rem_sub[DIV_W];
        rem_next = ge ? rem_sub[DIV_W-1:0] : rem_t[DIV_W-1:0];
        dvd_next = {dvd_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

[hdl/ddo_cordic.sv]
// ----------------------------------------------------------------------------
// ddo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, Q30 sine and cosine.
// ----------------------------------------------------------------------------
module ddo_cordic import ddo_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [31:0]            angle,
    output logic signed [CS_W-1:0] cos_o,
    output logic signed [CS_W-1:0] sin_o,
    output logic                   done
);

    logic signed [CS_W-1:0] x_reg, y_reg;
    logic signed [CZ_W-1:0] z_reg;
    logic [4:0]             i_reg;
    logic                   flip_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic                   flip_in;
    logic [31:0]            quarter;
    logic [31:0]            b;
    logic signed [CS_W-1:0] xs, ys;
    logic signed [CZ_W-1:0] at;

    always_comb begin
        quarter = angle + 32'h4000_0000;
        flip_in = quarter[31];
        b       = flip_in ? angle + 32'h8000_0000 : angle;
        xs      = x_reg >>> i_reg;
        ys      = y_reg >>> i_reg;
        at      = CZ_W'(atan_turns(i_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end else if (busy_reg) begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == 5'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= CZ_W'($signed(b));
            flip_reg <= flip_in;
        end else if (busy_reg) begin
            if (!z_reg[CZ_W-1]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign cos_o = flip_reg ? -x_reg : x_reg;
    assign sin_o = flip_reg ? -y_reg : y_reg;
    assign done  = done_reg;

endmodule

[hdl/ddo_ctrl.sv]
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer for one odometry update: issues datapath operations in order.
// ----------------------------------------------------------------------------
module ddo_ctrl import ddo_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_ML   = 5'd1;
    localparam logic [4:0] ST_MR   = 5'd2;
    localparam logic [4:0] ST_SD   = 5'd3;
    localparam logic [4:0] ST_MQ   = 5'd4;
    localparam logic [4:0] ST_DQS  = 5'd5;
    localparam logic [4:0] ST_DQW  = 5'd6;
    localparam logic [4:0] ST_CHK  = 5'd7;
    localparam logic [4:0] ST_CHS  = 5'd8;
    localparam logic [4:0] ST_CHW  = 5'd9;
    localparam logic [4:0] ST_MS   = 5'd10;
    localparam logic [4:0] ST_DFS  = 5'd11;
    localparam logic [4:0] ST_DFW  = 5'd12;
    localparam logic [4:0] ST_CMS  = 5'd13;
    localparam logic [4:0] ST_CMW  = 5'd14;
    localparam logic [4:0] ST_MC   = 5'd15;
    localparam logic [4:0] ST_TC   = 5'd16;
    localparam logic [4:0] ST_MX   = 5'd17;
    localparam logic [4:0] ST_DX   = 5'd18;
    localparam logic [4:0] ST_TS   = 5'd19;
    localparam logic [4:0] ST_MY   = 5'd20;
    localparam logic [4:0] ST_DY   = 5'd21;
    localparam logic [4:0] ST_DONE = 5'd22;

    logic [4:0] state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_ML;
                end
            end
            ST_ML:  begin cmd.op = OP_ML; state_next = ST_MR;  end
            ST_MR:  begin cmd.op = OP_MR; state_next = ST_SD;  end
            ST_SD:  begin cmd.op = OP_SD; state_next = ST_MQ;  end
            ST_MQ:  begin cmd.op = OP_MQ; state_next = ST_DQS; end
            ST_DQS: begin cmd.op = OP_DQ; state_next = ST_DQW; end
            ST_DQW: begin
                if (status.div_done) begin
                    cmd.op     = OP_Q;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                cmd.op     = OP_CHK;
                // no heading change: skip the half-angle sinc
                state_next = status.q_zero ? ST_CMS : ST_CHS;
            end
            ST_CHS: begin cmd.op = OP_CH; state_next = ST_CHW; end
            ST_CHW: begin
                if (status.cor_done) begin
                    state_next = ST_MS;
                end
            end
            ST_MS:  begin cmd.op = OP_MS; state_next = ST_DFS; end
            ST_DFS: begin cmd.op = OP_DF; state_next = ST_DFW; end
            ST_DFW: begin
                if (status.div_done) begin
                    cmd.op     = OP_F;
                    state_next = ST_CMS;
                end
            end
            ST_CMS: begin cmd.op = OP_CM; state_next = ST_CMW; end
            ST_CMW: begin
                if (status.cor_done) begin
                    state_next = ST_MC;
                end
            end
            ST_MC:  begin cmd.op = OP_MC; state_next = ST_TC; end
            ST_TC:  begin cmd.op = OP_TC; state_next = ST_MX; end
            ST_MX:  begin cmd.op = OP_MX; state_next = ST_DX; end
            ST_DX:  begin cmd.op = OP_DX; state_next = ST_TS; end
            ST_TS:  begin cmd.op = OP_TS; state_next = ST_MY; end
            ST_MY:  begin cmd.op = OP_MY; state_next = ST_DY; end
            ST_DY:  begin cmd.op = OP_DY; state_next = ST_DONE; end
            ST_DONE: begin
                // hold until the result register is free
                if (status.out_free) begin
                    cmd.op     = OP_DONE;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/ddo_datapath.sv]
// ----------------------------------------------------------------------------
// ddo_datapath
// Pose registers, shared multiplier, divider and CORDIC for the odometry core.
// ----------------------------------------------------------------------------
module ddo_datapath import ddo_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [15:0]        cfg_wr_data,
    input  logic signed [15:0] s_left_ticks,
    input  logic signed [15:0] s_right_ticks,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic               m_ready,
    output logic               m_valid,
    output logic signed [31:0] m_x_pos,
    output logic signed [31:0] m_y_pos,
    output logic [15:0]        m_heading
);

    localparam int DEN_SH = 40 - ANGLE_BITS;
    localparam int H_SH   = 31 - ANGLE_BITS;
    localparam int OLD_SH = 32 - ANGLE_BITS;
    localparam int PW     = 2 * MUL_W;

    logic [15:0]             wb_reg, dpt_reg;
    logic signed [15:0]      l_reg, r_reg;
    logic signed [33:0]      dl_reg, sum_reg, diff_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [DIV_W-1:0]        q_reg;
    logic [31:0]             h32_reg, mid_reg;
    logic                    s_neg_reg;
    logic signed [33:0]      f_reg;
    logic signed [MUL_W-1:0] t_reg;
    logic signed [30:0]      dx_reg, dy_reg;
    logic signed [31:0]      pos_x_reg, pos_y_reg;
    logic [ANGLE_BITS-1:0]   head_reg, head_next;
    logic                    m_valid_reg;
    logic signed [31:0]      m_x_reg, m_y_reg;
    logic [15:0]             m_head_reg;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic [15:0]             wb_eff;
    logic [DIV_W-1:0]        den, num;
    logic [33:0]             dmag;
    logic                    diff_neg;
    logic [31:0]             dth32, h32_c, old32;
    logic                    q_zero;
    logic signed [CS_W-1:0]  cor_cos, cor_sin;
    logic [CS_W-1:0]         smag;
    logic                    cor_done, div_done;
    logic [DIV_W-1:0]        div_quot, div_dvd, div_dsr;
    logic                    div_start, cor_start;
    logic [31:0]             cor_angle;
    logic signed [PW-1:0]    rnd30_full, rnd39_full;
    logic signed [33:0]      sx, sy;
    logic signed [31:0]      sat_x, sat_y;
    logic [15:0]             head16_next;
    logic                    out_free;

    // ---- arithmetic helpers
    always_comb begin
        wb_eff     = (wb_reg == 16'd0) ? 16'd1 : wb_reg;
        den        = DIV_W'(wb_eff) << DEN_SH;
        num        = prod_reg[DIV_W-1:0] + (den >> 1);
        diff_neg   = diff_reg[33];
        dmag       = diff_neg ? 34'(-diff_reg) : 34'(diff_reg);
        q_zero     = (q_reg == '0);
        dth32      = diff_neg ? 32'(-q_reg[31:0]) : q_reg[31:0];
        h32_c      = dth32 << H_SH;
        old32      = {head_reg, {OLD_SH{1'b0}}};
        smag       = cor_sin[CS_W-1] ? CS_W'(-cor_sin) : CS_W'(cor_sin);
        rnd30_full = prod_reg + PW'(64'sd536870912);
        rnd39_full = prod_reg + PW'(64'sd274877906944);
        head_next  = head_reg + dth32[ANGLE_BITS-1:0];
        sx         = 34'(pos_x_reg) + 34'(dx_reg);
        sy         = 34'(pos_y_reg) + 34'(dy_reg);
        // saturate to the signed 32-bit range
        if (sx[33:31] == 3'b000 || sx[33:31] == 3'b111) begin
            sat_x = sx[31:0];
        end else begin
            sat_x = sx[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        if (sy[33:31] == 3'b000 || sy[33:31] == 3'b111) begin
            sat_y = sy[31:0];
        end else begin
            sat_y = sy[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        out_free = !m_valid_reg || m_ready;
    end

    generate
        if (ANGLE_BITS >= 16) begin : g_head_down
            assign head16_next = head_next[ANGLE_BITS-1 -: 16];
        end else begin : g_head_up
            assign head16_next = {head_next, {(16 - ANGLE_BITS){1'b0}}};
        end
    endgenerate

    // ---- shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_ML: begin
                mul_a = MUL_W'(l_reg);
                mul_b = MUL_W'($signed({1'b0, dpt_reg}));
            end
            OP_MR: begin
                mul_a = MUL_W'(r_reg);
                mul_b = MUL_W'($signed({1'b0, dpt_reg}));
            end
            OP_MQ: begin
                mul_a = MUL_W'($signed({1'b0, dmag}));
                mul_b = MUL_W'($signed({1'b0, INV_TWO_PI_Q32}));
            end
            OP_MS: begin
                mul_a = MUL_W'($signed({1'b0, smag}));
                mul_b = MUL_W'($signed({1'b0, INV_PI_Q32}));
            end
            OP_MC: begin
                mul_a = MUL_W'(cor_cos);
                mul_b = MUL_W'(f_reg);
            end
            OP_DX: begin
                mul_a = MUL_W'(cor_sin);
                mul_b = MUL_W'(f_reg);
            end
            OP_MX, OP_MY: begin
                mul_a = MUL_W'(sum_reg);
                mul_b = t_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---- divider and CORDIC
    assign div_start = (cmd.op == OP_DQ) || (cmd.op == OP_DF);
    assign div_dvd   = (cmd.op == OP_DQ) ? num : (prod_reg[DIV_W-1:0] >> OLD_SH);
    assign div_dsr   = (cmd.op == OP_DQ) ? den : q_reg;
    assign cor_start = (cmd.op == OP_CH) || (cmd.op == OP_CM);
    assign cor_angle = (cmd.op == OP_CH) ? h32_reg : mid_reg;

    ddo_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (div_quot),
        .done     (div_done)
    );

    ddo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (cor_angle),
        .cos_o   (cor_cos),
        .sin_o   (cor_sin),
        .done    (cor_done)
    );

    // ---- working registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_LOAD: begin
                l_reg <= s_left_ticks;
                r_reg <= s_right_ticks;
            end
            OP_MR: dl_reg <= prod_reg[33:0];
            OP_SD: begin
                sum_reg  <= dl_reg + prod_reg[33:0];
                diff_reg <= prod_reg[33:0] - dl_reg;
            end
            OP_Q: q_reg <= div_quot;
            OP_CHK: begin
                h32_reg <= h32_c;
                if (q_zero) begin
                    mid_reg <= old32;
                    f_reg   <= 34'sd1073741824;
                end else begin
                    mid_reg <= old32 + h32_c;
                end
            end
            OP_MS: s_neg_reg <= cor_sin[CS_W-1];
            OP_F: begin
                if (s_neg_reg != diff_neg) begin
                    f_reg <= -$signed({1'b0, div_quot[32:0]});
                end else begin
                    f_reg <= $signed({1'b0, div_quot[32:0]});
                end
            end
            OP_TC, OP_TS: t_reg <= rnd30_full[MUL_W+29:30];
            OP_DX: dx_reg <= rnd39_full[PW-1:39];
            OP_DY: dy_reg <= rnd39_full[PW-1:39];
            OP_DONE: begin
                m_x_reg    <= sat_x;
                m_y_reg    <= sat_y;
                m_head_reg <= head16_next;
            end
            default: ;
        endcase
    end

    // ---- pose, configuration and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg      <= WHEEL_BASE_RST;
            dpt_reg     <= DIST_TICK_RST;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_WHEEL_BASE: wb_reg  <= cfg_wr_data;
                    REG_DIST_TICK:  dpt_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_DONE) begin
                pos_x_reg   <= sat_x;
                pos_y_reg   <= sat_y;
                head_reg    <= head_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.div_done = div_done;
    assign status.cor_done = cor_done;
    assign status.q_zero   = q_zero;
    assign status.out_free = out_free;

    assign m_valid   = m_valid_reg;
    assign m_x_pos   = m_x_reg;
    assign m_y_pos   = m_y_reg;
    assign m_heading = m_head_reg;

endmodule

[hdl/diff_drive_odometry_core.sv]
// ----------------------------------------------------------------------------
// diff_drive_odometry_core
// Arc-model dead-reckoning pose tracker for a two-wheeled robot.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------
//  s_      | in        | s_valid / s_ready | s_left_ticks, s_right_ticks
//  m_      | out       | m_valid / m_ready | m_x_pos, m_y_pos, m_heading
//  cfg_    | in        | cfg_wr_en         | cfg_addr, cfg_wr_data
//
// One beat in gives one beat out. An update runs two 64-step passes of the
// bit-serial divider and two 30-step CORDIC runs; with no heading change the
// sinc divide and first CORDIC are skipped. Reset is synchronous, active low;
// pose and heading clear to zero. A stalled output holds the core in its final
// step; a new input beat is taken only when the core is idle, while the last
// result may still wait.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core import ddo_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_left_ticks,
    input  logic signed [15:0] s_right_ticks,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_x_pos,
    output logic signed [31:0] m_y_pos,
    output logic [15:0]        m_heading
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ddo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .cmd     (cmd)
    );

    ddo_datapath #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_left_ticks  (s_left_ticks),
        .s_right_ticks (s_right_ticks),
        .cmd           (cmd),
        .status        (status),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_x_pos       (m_x_pos),
        .m_y_pos       (m_y_pos),
        .m_heading     (m_heading)
    );

    assign s_ready = cmd.in_ready;

endmodule

[dv/diff_drive_odometry_core_tb.sv]
// ----------------------------------------------------------------------------
// diff_drive_odometry_core_tb
// Self-checking bench for the odometry core. Each accepted input beat is run
// through a local model of the arc update (fixed-point divide, CORDIC, sinc
// term, saturation); each output beat is checked against the oldest
// predicted pose. Covers register extremes, saturation, back-pressure and
// random drive sequences with random idling on both channels.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core_tb;
    import ddo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 10000000;
    localparam int     SETTLE      = 300;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        h;
    } pose_t;

    localparam longint ATAN_TBL [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1
    };

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_addr;
    logic [15:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_left_ticks;
    logic signed [15:0] s_right_ticks;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_x_pos;
    logic signed [31:0] m_y_pos;
    logic [15:0]        m_heading;

    // local copy of the pose and registers
    longint      pose_x, pose_y;
    logic [15:0] pose_head;
    logic [15:0] wheel_base_reg, dist_tick_reg;

    pose_t  pose_q[$];
    int     errors;
    int     beats_in, beats_out;
    longint cycles;
    int     hold_cnt;
    bit     no_idle;

    diff_drive_odometry_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_left_ticks (s_left_ticks),
        .s_right_ticks(s_right_ticks),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_x_pos      (m_x_pos),
        .m_y_pos      (m_y_pos),
        .m_heading    (m_heading)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic longint rnd_shr(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat_pos(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // rotation-mode CORDIC, 2^32 per turn in, Q30 out
    task automatic cordic_sc(input logic [31:0] a, output longint c, output longint s);
        logic [31:0] t, b;
        logic        flip;
        longint      z, x, y, xs, ys;
        t    = a + 32'h4000_0000;
        flip = t[31];
        b    = flip ? a + 32'h8000_0000 : a;
        z    = longint'($signed(b));
        x    = 652032874;
        y    = 0;
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_pose(input logic signed [15:0] lt, input logic signed [15:0] rt);
        longint            dl, dr, sum, diff, dth, f, hc, hs, mc, ms, dx, dy, tmp;
        longint unsigned   wb, dmag, den, q, smag, fm;
        logic [31:0]       old32, mid32, h32;
        pose_t             p;
        wb   = (wheel_base_reg == 16'd0) ? 64'd1 : 64'(wheel_base_reg);
        dl   = longint'(lt) * longint'(dist_tick_reg);
        dr   = longint'(rt) * longint'(dist_tick_reg);
        sum  = dl + dr;
        diff = dr - dl;
        dmag = (diff < 0) ? longint'(-diff) : longint'(diff);
        den  = wb << 24;
        q    = (dmag * 64'd683565276 + den / 64'd2) / den;
        dth  = (diff < 0) ? -longint'(q) : longint'(q);
        old32 = {pose_head, 16'h0000};
        mid32 = old32;
        f     = 64'sd1 <<< 30;
        if (dth != 0) begin
            tmp = dth <<< 15;
            h32 = tmp[31:0];
            cordic_sc(h32, hc, hs);
            smag  = (hs < 0) ? longint'(-hs) : longint'(hs);
            fm    = ((smag * 64'd1367130551) >> 16) / q;
            f     = ((hs < 0) != (dth < 0)) ? -longint'(fm) : longint'(fm);
            mid32 = old32 + h32;
        end
        cordic_sc(mid32, mc, ms);
        dx = rnd_shr(sum * rnd_shr(mc * f, 30), 39);
        dy = rnd_shr(sum * rnd_shr(ms * f, 30), 39);
        pose_x    = sat_pos(pose_x + dx);
        pose_y    = sat_pos(pose_y + dy);
        pose_head = pose_head + dth[15:0];
        p.x = pose_x[31:0];
        p.y = pose_y[31:0];
        p.h = pose_head;
        pose_q.push_back(p);
    endtask

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // one input beat; valid stays up between back-to-back beats
    task automatic send_ticks(input logic signed [15:0] lt, input logic signed [15:0] rt);
        int g;
        g = gap_len();
        @(negedge aclk);
        if (g > 0) begin
            s_valid = 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
        s_left_ticks  = lt;
        s_right_ticks = rt;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_pose(lt, rt);
        beats_in++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        wait (pose_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        if (idx == REG_WHEEL_BASE) wheel_base_reg = val;
        else                       dist_tick_reg  = val;
    endtask

    task automatic set_geometry(input logic [15:0] wb, input logic [15:0] dpt);
        drain();
        write_reg(REG_WHEEL_BASE, wb);
        write_reg(REG_DIST_TICK, dpt);
    endtask

    function automatic logic [15:0] rand_ticks();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'($signed($urandom_range(0, 400)) - 200);
        if (r < 6) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return 16'($urandom);
    endfunction

    // receiver: random stalls plus counted long hold-offs
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70)      m_ready <= 1'b1;
            else if (r < 97) m_ready <= 1'b0;
            else begin
                m_ready  <= 1'b0;
                hold_cnt <= $urandom_range(20, 300);
            end
        end
    end

    always @(posedge aclk) begin
        pose_t e;
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (pose_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected output beat x=%0d y=%0d h=%0d",
                         $time, m_x_pos, m_y_pos, m_heading);
            end else begin
                e = pose_q.pop_front();
                if (m_x_pos !== e.x) begin
                    errors++;
                    $display("%0t: x_pos expected %0d actual %0d", $time, e.x, m_x_pos);
                end
                if (m_y_pos !== e.y) begin
                    errors++;
                    $display("%0t: y_pos expected %0d actual %0d", $time, e.y, m_y_pos);
                end
                if (m_heading !== e.h) begin
                    errors++;
                    $display("%0t: heading expected %0d actual %0d", $time, e.h, m_heading);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, pose_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed();
        send_ticks(16'sd0, 16'sd0);
        send_ticks(16'sd100, 16'sd100);
        send_ticks(16'sh7fff, 16'sh7fff);
        send_ticks(16'sh8000, 16'sh8000);
        send_ticks(16'sh7fff, 16'sh8000);
        send_ticks(16'sh8000, 16'sh7fff);
        send_ticks(-16'sd50, 16'sd50);
        send_ticks(16'sd30, 16'sd10);
        send_ticks(16'sd1, 16'sd0);
        send_ticks(16'sd0, -16'sd1);
        send_ticks(-16'sd1, -16'sd1);
    endtask

    task automatic test_register_extremes();
        // zero wheel base acts as one: huge heading changes, multi-turn arcs
        set_geometry(16'd0, 16'd19903);
        send_ticks(16'sd3, 16'sd5);
        send_ticks(16'sh7fff, 16'sh8000);
        set_geometry(16'd1, 16'd65535);
        send_ticks(16'sd1, -16'sd1);
        send_ticks(16'sh8000, 16'sh7fff);
        set_geometry(16'd65535, 16'd1);
        send_ticks(16'sd1, 16'sd2);
        send_ticks(16'sh7fff, 16'sh7fff);
        // no distance per tick: pose holds
        set_geometry(16'd3840, 16'd0);
        send_ticks(16'sh7fff, 16'sh8000);
        send_ticks(16'sd500, 16'sd500);
    endtask

    task automatic test_saturation();
        set_geometry(16'd65535, 16'd65535);
        for (int i = 0; i < 300; i++) send_ticks(16'sh7fff, 16'sh7fff);
        for (int i = 0; i < 20; i++)  send_ticks(16'sh8000, 16'sh8000);
        set_geometry(16'd65535, 16'd65535);
        for (int i = 0; i < 300; i++) send_ticks(16'sh8000, 16'sh8000);
    endtask

    task automatic test_backpressure();
        set_geometry(16'd3840, 16'd19903);
        // load the hold-off away from the receiver's edge
        @(posedge aclk);
        hold_cnt = 2000;
        no_idle  = 1'b1;
        for (int i = 0; i < 12; i++) send_ticks(rand_ticks(), rand_ticks());
        no_idle = 1'b0;
        // pause the sender until the pipe is empty
        @(negedge aclk);
        s_valid = 1'b0;
        wait (pose_q.size() == 0);
        for (int i = 0; i < 8; i++) send_ticks(rand_ticks(), rand_ticks());
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_geometry(16'd3840, 16'd19903);
                1: set_geometry(16'd1, 16'd1);
                2: set_geometry(16'd65535, 16'd65535);
                default: set_geometry(16'($urandom), 16'($urandom));
            endcase
            no_idle = (ph == 3);
            for (int i = 0; i < 200; i++) begin
                if ($urandom_range(0, 3) != 0) begin
                    logic signed [15:0] base, turn;
                    base = 16'($signed($urandom_range(0, 600)) - 300);
                    turn = 16'($signed($urandom_range(0, 40)) - 20);
                    send_ticks(base - turn, base + turn);
                end else begin
                    send_ticks(rand_ticks(), rand_ticks());
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        errors = 0; beats_in = 0; beats_out = 0; cycles = 0;
        hold_cnt = 0; no_idle = 1'b0;
        cfg_wr_en = 1'b0; cfg_addr = REG_WHEEL_BASE; cfg_wr_data = '0;
        s_valid = 1'b0; s_left_ticks = '0; s_right_ticks = '0;
        pose_x = 0; pose_y = 0; pose_head = '0;
        wheel_base_reg = WHEEL_BASE_RST;
        dist_tick_reg  = DIST_TICK_RST;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_register_extremes();
        test_saturation();
        test_backpressure();
        test_random();
        drain();

        $display("Covered %0d input beats and %0d output beats over default, extreme",
                 beats_in, beats_out);
        $display("and random geometry, saturation and long output stalls.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
hdl/ddo_pkg.sv
hdl/ddo_div.sv
hdl/ddo_cordic.sv
hdl/ddo_ctrl.sv
hdl/ddo_datapath.sv
hdl/diff_drive_odometry_core.sv
dv/diff_drive_odometry_core_tb.sv
